FILE: hw/rtl/dtf_pkg.sv
package dtf_pkg;

  localparam int unsigned VertexW      = 21;
  localparam int unsigned HashW        = 32;
  localparam int unsigned EpochW       = 8;
  localparam int unsigned CountW       = 13;
  localparam int unsigned TableEntries = 4096;
  localparam int unsigned ProbeLimit   = 8;

  localparam logic [HashW-1:0]  HashMix  = 32'h9e37_79b9;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic [VertexW-1:0] vertex_a;
    logic [VertexW-1:0] vertex_b;
    logic [VertexW-1:0] vertex_c;
    logic               start_of_mesh;
  } in_item_t;

  typedef struct packed {
    logic is_duplicate;
    logic table_overflow;
  } out_item_t;

  // Sorted triple, smallest index first.
  typedef struct packed {
    logic [VertexW-1:0] lo;
    logic [VertexW-1:0] mid;
    logic [VertexW-1:0] hi;
  } key_t;

  // An entry counts as present only when its epoch matches the current one.
  typedef struct packed {
    logic              valid;
    logic [EpochW-1:0] epoch;
    key_t              key;
  } entry_t;

  typedef struct packed {
    logic             done;
    logic [HashW-1:0] hash;
    key_t             key;
  } key_status_t;

  function automatic logic [HashW-1:0] mix_in(logic [HashW-1:0] h, logic [VertexW-1:0] v);
    logic [HashW-1:0] sum;
    sum = HashW'(v) + HashMix + {h[HashW-7:0], 6'b0} + {2'b0, h[HashW-1:2]};
    return h ^ sum;
  endfunction

endpackage

FILE: hw/rtl/duplicate_triangle_filter.sv
// Duplicate triangle filter: each input transfer carries one triangle as three vertex indices;
// the block sorts them, hashes the sorted triple and looks it up in a linearly probed hash set
// held in a single-port table memory, giving one result transfer per triangle (duplicate, or
// kept, or overflow when no free slot lies within PROBE_LIMIT probes). A triangle is sorted,
// hashed in three rounds and then probed slot by slot through the single memory port, and
// the block takes one triangle at a time. After reset the block sweeps the whole table,
// clearing every entry, before it accepts its first triangle. Start of mesh normally empties
// the set at once by moving to a new epoch; on every 256th start of mesh the epoch wraps and
// the same sweep runs before that triangle is handled. TABLE_ENTRIES must be a power of two.
module duplicate_triangle_filter #(
  parameter int unsigned TABLE_ENTRIES = dtf_pkg::TableEntries,
  parameter int unsigned PROBE_LIMIT   = dtf_pkg::ProbeLimit
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dtf_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dtf_pkg::out_item_t out_item_o
);
  import dtf_pkg::*;

  localparam int unsigned AddrW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned ProbeW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam logic [ProbeW-1:0] ProbeLast = ProbeW'(PROBE_LIMIT - 1);
  localparam logic [AddrW-1:0]  AddrLast  = AddrW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY,
    ST_CHECK
  } state_e;

  state_e            state_q, state_d;
  logic              pending_q, pending_d;
  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;
  logic [AddrW-1:0]  slot_q, slot_d;
  logic [ProbeW-1:0] probe_q, probe_d;
  logic [EpochW-1:0] epoch_q, epoch_d;
  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic        in_fire;
  logic        out_free;
  key_status_t kstat;
  logic        mem_en, mem_we;
  logic [AddrW-1:0] mem_addr;
  entry_t      mem_wdata, mem_rdata;
  logic        present, match;

  assign in_fire  = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign present  = mem_rdata.valid && (mem_rdata.epoch == epoch_q);
  assign match    = present && (mem_rdata.key == kstat.key);

  dtf_keygen u_keygen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .item_i   (in_item_i),
    .status_o (kstat)
  );

  dtf_table #(
    .Depth (TABLE_ENTRIES),
    .AddrW (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    clr_addr_d  = clr_addr_q;
    slot_d      = slot_q;
    probe_d     = probe_q;
    epoch_d     = epoch_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = slot_q;
    mem_wdata   = '{valid: 1'b1, epoch: epoch_q, key: kstat.key};

    unique case (state_q)
      ST_CLEAR: begin
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrLast) begin
          pending_d = 1'b0;
          state_d   = pending_q ? ST_KEY : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_KEY;
          if (in_item_i.start_of_mesh) begin
            count_d = '0;
            if (epoch_q == {EpochW{1'b1}}) begin
              epoch_d    = '0;
              clr_addr_d = '0;
              pending_d  = 1'b1;
              state_d    = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + EpochW'(1);
            end
          end
        end
      end
      ST_KEY: begin
        if (kstat.done) begin
          mem_en   = 1'b1;
          mem_addr = kstat.hash[AddrW-1:0];
          slot_d   = kstat.hash[AddrW-1:0];
          probe_d  = '0;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!present) begin
          if (out_free) begin
            mem_en      = 1'b1;
            mem_we      = 1'b1;
            if (count_q != CountMax) begin
              count_d = count_q + CountW'(1);
            end
            out_valid_d = 1'b1;
            out_d       = '{is_duplicate: 1'b0, table_overflow: 1'b0};
            state_d     = ST_IDLE;
          end
        end else if (match) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{is_duplicate: 1'b1, table_overflow: 1'b0};
            state_d     = ST_IDLE;
          end
        end else if (probe_q == ProbeLast) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{is_duplicate: 1'b0, table_overflow: 1'b1};
            state_d     = ST_IDLE;
          end
        end else begin
          // Occupied by another triple: read the next slot, wrapping round the table.
          mem_en   = 1'b1;
          mem_addr = slot_q + AddrW'(1);
          slot_d   = slot_q + AddrW'(1);
          probe_d  = probe_q + ProbeW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pending_q   <= 1'b0;
      clr_addr_q  <= '0;
      epoch_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      clr_addr_q  <= clr_addr_d;
      epoch_q     <= epoch_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    probe_q <= probe_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: hw/rtl/dtf_table.sv
module dtf_table #(
  parameter int unsigned Depth = dtf_pkg::TableEntries,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  dtf_pkg::entry_t  wdata_i,
  output dtf_pkg::entry_t  rdata_o
);
  import dtf_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/dtf_keygen.sv
module dtf_keygen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  dtf_pkg::in_item_t    item_i,
  output dtf_pkg::key_status_t status_o
);
  import dtf_pkg::*;

  key_t             key_q, key_d;
  logic [HashW-1:0] hash_q, hash_d;
  logic [1:0]       step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [VertexW-1:0] s0, s1, s2, t;
  logic [VertexW-1:0] mix_v;

  // Three compare-exchange stages put the indices in ascending order.
  always_comb begin
    t  = '0;
    s0 = item_i.vertex_a;
    s1 = item_i.vertex_b;
    s2 = item_i.vertex_c;
    if (s0 > s1) begin
      t = s0; s0 = s1; s1 = t;
    end
    if (s1 > s2) begin
      t = s1; s1 = s2; s2 = t;
    end
    if (s0 > s1) begin
      t = s0; s0 = s1; s1 = t;
    end
  end

  always_comb begin
    case (step_q)
      2'd0:    mix_v = key_q.lo;
      2'd1:    mix_v = key_q.mid;
      default: mix_v = key_q.hi;
    endcase
  end

  always_comb begin
    key_d  = key_q;
    hash_d = hash_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      key_d  = '{lo: s0, mid: s1, hi: s2};
      hash_d = '0;
      step_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      hash_d = mix_in(hash_q, mix_v);
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    hash_q <= hash_d;
  end

  assign status_o = '{done: done_q, hash: hash_q, key: key_q};

endmodule
